### hdl/sgr_pkg.sv
// ----------------------------------------------------------------------------
// sgr_pkg
// shared types and constants of the sgr attribute parser
// ----------------------------------------------------------------------------
package sgr_pkg;

  localparam int unsigned SeqDepth  = 32;
  localparam int unsigned PtrBits   = $clog2(SeqDepth);
  localparam int unsigned CntBits   = $clog2(SeqDepth + 1);
  localparam int unsigned ArgBits   = 16;
  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned CfgDataBits = 24;

  localparam logic [7:0] EscByte   = 8'h1b;
  localparam logic [7:0] LbrByte   = 8'h5b;
  localparam logic [7:0] SemiByte  = 8'h3b;
  localparam logic [7:0] MByte     = 8'h6d;
  localparam logic [7:0] ZeroByte  = 8'h30;
  localparam logic [7:0] NineByte  = 8'h39;

  // register indexes
  localparam logic [CfgIdxBits-1:0] RegFgKind  = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegFgColor = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegBgKind  = 2'd2;
  localparam logic [CfgIdxBits-1:0] RegBgColor = 2'd3;

  // code phases
  localparam logic [2:0] CpNormal = 3'd0;
  localparam logic [2:0] CpExt    = 3'd1;
  localparam logic [2:0] CpIndex  = 3'd2;
  localparam logic [2:0] CpRed    = 3'd3;
  localparam logic [2:0] CpGreen  = 3'd4;
  localparam logic [2:0] CpBlue   = 3'd5;
  localparam logic [2:0] CpIgnore = 3'd6;

  typedef struct packed {
    logic [1:0]  fg_kind;
    logic [23:0] fg_color;
    logic [1:0]  bg_kind;
    logic [23:0] bg_color;
    logic [7:0]  mode;
  } attr_t;

  typedef struct packed {
    logic [7:0] text_byte;
    attr_t      attr;
    logic       run_last;
    logic       text_end;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic start_seq;   // esc seen in text: copy committed to working
    logic push;        // store byte in replay buffer
    logic clr_acc;
    logic add_digit;
    logic apply;       // apply accumulated argument
    logic commit;
    logic rd_start;    // launch replay read at index 0
    logic rd_next;     // advance replay read
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic             apply_ok;   // apply would not abort
    logic             commit_ok;  // apply ok and not mid color
    logic [CntBits-1:0] count;
  } sts_t;

endpackage

### hdl/sgr_if.sv
// ----------------------------------------------------------------------------
// sgr_byte_if / sgr_res_if
// valid/ready channels for input bytes and result words
// ----------------------------------------------------------------------------
interface sgr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface sgr_res_if;
  import sgr_pkg::*;
  logic        valid;
  logic        ready;
  logic [7:0]  text_byte;
  logic [1:0]  fg_kind;
  logic [23:0] fg_color;
  logic [1:0]  bg_kind;
  logic [23:0] bg_color;
  logic [7:0]  mode_bits;
  logic        run_last;
  logic        text_end;
  modport source (output valid, output text_byte, output fg_kind, output fg_color,
                  output bg_kind, output bg_color, output mode_bits, output run_last,
                  output text_end, input ready);
  modport sink (input valid, input text_byte, input fg_kind, input fg_color,
                input bg_kind, input bg_color, input mode_bits, input run_last,
                input text_end, output ready);
endinterface

### hdl/sgr_ram.sv
// ----------------------------------------------------------------------------
// sgr_ram
// generic single write, single read ram with registered read
// ----------------------------------------------------------------------------
module sgr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### hdl/sgr_datapath.sv
// ----------------------------------------------------------------------------
// sgr_datapath
// attribute registers, argument accumulator, code decode and replay buffer
// ----------------------------------------------------------------------------
module sgr_datapath import sgr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  input  logic [7:0]             byte_i,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  output attr_t                  committed_o,
  output logic [7:0]             rd_data_o
);
  localparam logic [ArgBits-1:0] ArgMax = {ArgBits{1'b1}};

  attr_t              cmt_q, wrk_q, wrk_d, rst_attr_q;
  logic [2:0]         cp_q, cp_d;
  logic               tbg_q, tbg_d;
  logic [ArgBits-1:0] acc_q;
  logic [CntBits-1:0] cnt_q;
  logic [PtrBits-1:0] rd_ptr_q, raddr;
  logic               ok;

  // reset attribute registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rst_attr_q <= '{fg_kind: 2'd0, fg_color: 24'd7, bg_kind: 2'd0, bg_color: 24'd0,
                      mode: 8'd0};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegFgKind:  rst_attr_q.fg_kind  <= cfg_data_i[1:0];
        RegFgColor: rst_attr_q.fg_color <= cfg_data_i;
        RegBgKind:  rst_attr_q.bg_kind  <= cfg_data_i[1:0];
        RegBgColor: rst_attr_q.bg_color <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // argument decode into the working copy
  logic [23:0] tcol, newc;
  logic [7:0]  low8;
  always_comb begin
    wrk_d = wrk_q;
    cp_d  = cp_q;
    tbg_d = tbg_q;
    ok    = 1'b1;
    low8  = acc_q[7:0];
    tcol  = tbg_q ? wrk_q.bg_color : wrk_q.fg_color;
    newc  = 24'd0;
    case (cp_q)
      CpNormal: begin
        if (acc_q == '0) begin
          wrk_d = rst_attr_q;
        end else if (acc_q <= ArgBits'(8)) begin
          wrk_d.mode = wrk_q.mode | (8'd1 << (acc_q[2:0] - 3'd1));
        end else if (acc_q == ArgBits'(9)) begin
          wrk_d = wrk_q;
        end else if (acc_q >= ArgBits'(30) && acc_q <= ArgBits'(37)) begin
          wrk_d.fg_kind = 2'd0; wrk_d.fg_color = 24'(acc_q - ArgBits'(30));
        end else if (acc_q >= ArgBits'(40) && acc_q <= ArgBits'(47)) begin
          wrk_d.bg_kind = 2'd0; wrk_d.bg_color = 24'(acc_q - ArgBits'(40));
        end else if (acc_q >= ArgBits'(90) && acc_q <= ArgBits'(97)) begin
          wrk_d.fg_kind = 2'd1; wrk_d.fg_color = 24'(acc_q - ArgBits'(90));
        end else if (acc_q >= ArgBits'(100) && acc_q <= ArgBits'(107)) begin
          wrk_d.bg_kind = 2'd1; wrk_d.bg_color = 24'(acc_q - ArgBits'(100));
        end else if (acc_q == ArgBits'(38) || acc_q == ArgBits'(48)) begin
          tbg_d = (acc_q == ArgBits'(48));
          cp_d  = CpExt;
        end else begin
          cp_d = CpIgnore;
        end
      end
      CpExt: begin
        if (acc_q == ArgBits'(5)) cp_d = CpIndex;
        else if (acc_q == ArgBits'(2)) cp_d = CpRed;
        else ok = 1'b0;
      end
      CpIndex, CpRed, CpGreen, CpBlue: begin
        if (cp_q == CpIndex) newc = {16'd0, low8};
        else if (cp_q == CpRed) newc = 24'(acc_q);
        else newc = 24'({tcol, 8'd0} | 32'(acc_q));
        if (cp_q == CpIndex && acc_q > ArgBits'(255)) ok = 1'b0;
        if (tbg_q) begin
          wrk_d.bg_kind  = (cp_q == CpIndex) ? 2'd2 : 2'd3;
          wrk_d.bg_color = newc;
        end else begin
          wrk_d.fg_kind  = (cp_q == CpIndex) ? 2'd2 : 2'd3;
          wrk_d.fg_color = newc;
        end
        cp_d = (cp_q == CpRed) ? CpGreen : (cp_q == CpGreen) ? CpBlue : CpNormal;
      end
      default: ;
    endcase
  end

  assign sts_o.apply_ok  = ok;
  assign sts_o.commit_ok = ok && !(cp_d == CpIndex || cp_d == CpRed ||
                                   cp_d == CpGreen || cp_d == CpBlue);
  assign sts_o.count     = cnt_q;
  assign committed_o     = cmt_q;

  // saturating decimal accumulate
  logic [ArgBits+3:0] acc_ext;
  assign acc_ext = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + (ArgBits+4)'(byte_i[3:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmt_q <= '{fg_kind: 2'd0, fg_color: 24'd7, bg_kind: 2'd0, bg_color: 24'd0, mode: 8'd0};
      wrk_q <= '{fg_kind: 2'd0, fg_color: 24'd7, bg_kind: 2'd0, bg_color: 24'd0, mode: 8'd0};
      cp_q  <= CpNormal;
      tbg_q <= 1'b0;
      acc_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.start_seq) begin
        wrk_q <= cmt_q; cp_q <= CpNormal; tbg_q <= 1'b0; cnt_q <= '0;
      end
      if (cmd_i.apply) begin
        wrk_q <= wrk_d; cp_q <= cp_d; tbg_q <= tbg_d;
      end
      if (cmd_i.commit) begin
        cmt_q <= wrk_d; cp_q <= CpNormal; cnt_q <= '0;
      end
      if (cmd_i.rd_start) begin
        cp_q <= CpNormal;
      end
      if (cmd_i.push) cnt_q <= cnt_q + CntBits'(1);
      if (cmd_i.clr_acc) acc_q <= '0;
      else if (cmd_i.add_digit) begin
        acc_q <= (acc_ext > (ArgBits+4)'(ArgMax)) ? ArgMax : acc_ext[ArgBits-1:0];
      end
    end
  end

  // replay read pointer, holds the address of the word on the read port
  assign raddr = cmd_i.rd_start ? '0 : rd_ptr_q + PtrBits'(cmd_i.rd_next);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rd_ptr_q <= '0;
    else rd_ptr_q <= raddr;
  end

  sgr_ram #(.Width(8), .Depth(SeqDepth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (cnt_q[PtrBits-1:0]),
    .wdata_i (byte_i),
    .raddr_i (raddr),
    .rdata_o (rd_data_o)
  );
endmodule

### hdl/sgr_ctrl.sv
// ----------------------------------------------------------------------------
// sgr_ctrl
// lexer state machine, replay sequencing and output register
// ----------------------------------------------------------------------------
module sgr_ctrl import sgr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  output logic       in_ready_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output res_t       out_o,
  output cmd_t       cmd_o,
  input  sts_t       sts_i,
  input  attr_t      committed_i,
  input  logic [7:0] rd_data_i
);
  localparam logic [1:0] StText   = 2'd0;
  localparam logic [1:0] StEsc    = 2'd1;
  localparam logic [1:0] StArgs   = 2'd2;
  localparam logic [1:0] StReplay = 2'd3;

  logic [1:0]         st_q, st_d;
  logic [CntBits-1:0] left_q, left_d;   // replay words still to send
  logic [7:0]         pend_q, pend_d;   // offending byte handled after replay
  logic               rd_vld_q;         // ram data valid this cycle
  logic               ov_q, ov_d;
  res_t               o_q, o_d;
  logic               take, free, is_digit, room, abort, txt;

  assign free     = !ov_q || out_ready_i;
  assign is_digit = in_byte_i >= ZeroByte && in_byte_i <= NineByte;
  assign room     = sts_i.count < CntBits'(SeqDepth);
  assign in_ready_o  = (st_q != StReplay) && free;
  assign take     = in_valid_i && in_ready_o;
  assign out_valid_o = ov_q;
  assign out_o       = o_q;

  always_comb begin
    st_d   = st_q;
    left_d = left_q;
    pend_d = pend_q;
    ov_d   = ov_q && !out_ready_i;
    o_d    = o_q;
    cmd_o  = '0;
    abort  = 1'b0;
    txt    = 1'b0;
    unique case (st_q)
      StText: if (take) txt = 1'b1;
      StEsc: if (take) begin
        if (in_byte_i == LbrByte && room) begin
          cmd_o.push = 1'b1; cmd_o.clr_acc = 1'b1; st_d = StArgs;
        end else abort = 1'b1;
      end
      StArgs: if (take) begin
        if (in_byte_i == MByte) begin
          if (sts_i.commit_ok) begin
            cmd_o.commit = 1'b1; cmd_o.clr_acc = 1'b1; st_d = StText;
          end else abort = 1'b1;
        end else if ((in_byte_i == SemiByte || is_digit) && room) begin
          if (in_byte_i == SemiByte) begin
            if (sts_i.apply_ok) begin
              cmd_o.apply = 1'b1; cmd_o.clr_acc = 1'b1; cmd_o.push = 1'b1;
            end else abort = 1'b1;
          end else begin
            cmd_o.add_digit = 1'b1; cmd_o.push = 1'b1;
          end
        end else abort = 1'b1;
      end
      StReplay: begin
        if (rd_vld_q && free) begin
          ov_d = 1'b1;
          o_d  = '{text_byte: rd_data_i, attr: committed_i, run_last: 1'b0, text_end: 1'b0};
          left_d = left_q - CntBits'(1);
          if (left_q != CntBits'(1)) cmd_o.rd_next = 1'b1;
          else begin
            st_d = StText;
            // offending byte handled as text
            if (pend_q == EscByte) begin
              cmd_o.start_seq = 1'b1; st_d = StEsc;
              o_d.run_last = 1'b1;
            end else begin
              o_d.run_last = 1'b1;
              ov_d = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    if (abort) begin
      cmd_o.clr_acc = 1'b1;
      if (sts_i.count != '0) begin
        cmd_o.rd_start = 1'b1; pend_d = in_byte_i;
        left_d = sts_i.count; st_d = StReplay;
      end else begin
        st_d = StText; txt = 1'b1;
      end
    end
    if (txt) begin
      st_d = StText;
      if (in_byte_i == EscByte) begin
        cmd_o.start_seq = 1'b1; st_d = StEsc;
      end else begin
        ov_d = 1'b1;
        o_d  = '{text_byte: in_byte_i, attr: committed_i, run_last: 1'b1,
                 text_end: (in_byte_i == 8'd0)};
      end
    end
    if (cmd_o.rd_start) cmd_o.clr_acc = 1'b1;
  end

  // pending byte after replay needs its own word unless it is esc
  logic pend_word_q;
  logic [1:0] st_n;
  always_comb begin
    st_n = st_d;
    if (st_q == StReplay && rd_vld_q && free && left_q == CntBits'(1) && pend_q != EscByte)
      st_n = StReplay;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StText; left_q <= '0; ov_q <= 1'b0; rd_vld_q <= 1'b0;
      pend_word_q <= 1'b0;
    end else begin
      if (pend_word_q) begin
        if (free) begin
          pend_word_q <= 1'b0; st_q <= StText; ov_q <= 1'b1;
        end else ov_q <= ov_d;
      end else begin
        st_q <= st_n; left_q <= left_d; ov_q <= ov_d;
        pend_word_q <= (st_n == StReplay) && (st_d != StReplay);
      end
      rd_vld_q <= cmd_o.rd_start || cmd_o.rd_next ||
                  (rd_vld_q && !(st_q == StReplay && free) && !pend_word_q);
    end
  end

  // result register; pending byte word fixed up after replay
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (pend_word_q) begin
      if (free) o_q <= '{text_byte: pend_q, attr: committed_i, run_last: 1'b1,
                         text_end: (pend_q == 8'd0)};
    end else if (st_q == StReplay && rd_vld_q && free && left_q == CntBits'(1) &&
                 pend_q != EscByte) begin
      o_q <= '{text_byte: rd_data_i, attr: committed_i, run_last: 1'b0, text_end: 1'b0};
    end else begin
      o_q <= o_d;
    end
  end
endmodule

### hdl/sgr_escape_attribute_parser_core.sv
// ----------------------------------------------------------------------------
// sgr_escape_attribute_parser_core
// sgr escape sequence parser tagging text bytes with attributes
// ----------------------------------------------------------------------------
// Input channel in_if carries one input byte per word; output channel out_if
// carries one tagged text byte per word, with run_last on the last word a byte
// causes and text_end on the end-of-text word (input byte 0).
// Text bytes and sequence bytes are taken one per cycle while the output is
// free and no replay runs; a text byte shows on the output in the cycle after
// it is taken. Escape and sequence bytes give no word. A malformed sequence
// replays its buffered bytes (up to 32) one word a cycle from the replay ram
// while the receiver accepts; input is held off until they and the offending
// byte's own word, unless that byte is esc, have passed the output register.
// The reset color registers are written through cfg_we_i / cfg_idx_i /
// cfg_data_i, by the user only while the block is idle; the block does not check it.
// Reset clears committed and working attributes to the register reset values
// and puts the lexer in text. When the receiver stalls, the output register
// holds its word and input is taken no further.
// ----------------------------------------------------------------------------
module sgr_escape_attribute_parser_core import sgr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  sgr_byte_if.sink               in_if,
  sgr_res_if.source              out_if
);
  cmd_t       cmd;
  sts_t       sts;
  attr_t      cmt;
  logic [7:0] rd_data;
  res_t       res;

  sgr_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .byte_i (in_if.in_byte), .cmd_i (cmd), .sts_o (sts),
    .committed_o (cmt), .rd_data_o (rd_data)
  );

  sgr_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid), .in_byte_i (in_if.in_byte), .in_ready_o (in_if.ready),
    .out_ready_i (out_if.ready), .out_valid_o (out_if.valid), .out_o (res),
    .cmd_o (cmd), .sts_i (sts), .committed_i (cmt), .rd_data_i (rd_data)
  );

  assign out_if.text_byte = res.text_byte;
  assign out_if.fg_kind   = res.attr.fg_kind;
  assign out_if.fg_color  = res.attr.fg_color;
  assign out_if.bg_kind   = res.attr.bg_kind;
  assign out_if.bg_color  = res.attr.bg_color;
  assign out_if.mode_bits = res.attr.mode;
  assign out_if.run_last  = res.run_last;
  assign out_if.text_end  = res.text_end;
endmodule
